FILE: rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  // Operand and internal widths
  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int MAG_W         = 2 * OPERAND_WIDTH + 1;
  localparam int K_W           = $clog2(MAG_W + 1);
  localparam int DCNT_W        = $clog2(MAG_W + 1);
  localparam int RES_NUM_W     = 34;
  localparam int RES_DEN_W     = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/rau_in_if.sv
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface
`default_nettype wire

FILE: rtl/rau_out_if.sv
`default_nettype none
interface rau_out_if;
  import rau_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic [1:0]                  status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/rau_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module rau_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rau_pkg::MAG_W-1:0] dividend,
  input  wire logic [rau_pkg::MAG_W-1:0] divisor,
  output logic                           done,
  output logic [rau_pkg::MAG_W-1:0]      quotient
);
  import rau_pkg::*;

  logic [MAG_W:0]    rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [MAG_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MAG_W:0]    rem_sh;
  logic [MAG_W:0]    rem_sub;

  // shift in next dividend bit and trial subtract
  assign rem_sh   = {rem_r[MAG_W-1:0], quo_r[MAG_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!rem_sub[MAG_W]) begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[MAG_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rational_arith_unit_top.sv
`default_nettype none
// Sequence: multiply steps on the shared multiplier, binary-gcd steps until
// x reaches zero, two divisions by the gcd (numerator, then denominator,
// 33 quotient bits each) and the output register.
// Throughput: one request at a time; the next is taken once the result is
// in the output register. Error requests go straight to the output state.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module rational_arith_unit_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rau_in_if.sink     in_req,
  rau_out_if.source  out_res
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t                          state_r;
  logic [1:0]                      op_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [1:0]                      step_r;
  logic signed [PROD_W-1:0]        prod_r;
  logic signed [MAG_W-1:0]         num_r;
  logic [MAG_W-1:0]                x_r, y_r, nmag_r, dmag_r, g_r, qn_r, qd_r;
  logic [K_W-1:0]                  k_r;
  logic                            neg_r;
  logic [1:0]                      st_r;
  logic                            div_start_r;
  logic                            div_done;
  logic [MAG_W-1:0]                div_q;
  logic [MAG_W-1:0]                div_a;
  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]        mul_p;
  logic signed [MAG_W-1:0]         prod_x;
  logic signed [MAG_W-1:0]         num_fin;
  logic signed [MAG_W-1:0]         den_x;
  logic signed [MAG_W:0]           res_s;
  logic                            out_valid_r;
  logic signed [RES_NUM_W-1:0]     res_num_r;
  logic [RES_DEN_W-1:0]            res_den_r;
  logic [1:0]                      status_r;

  // shared multiplier operand select by step and operation
  always_comb begin
    unique case (step_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase
  end
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_x = MAG_W'(prod_r);

  // numerator combine at step 2, final values at step 3
  assign num_fin = num_r;
  assign den_x   = MAG_W'(prod_r);

  assign div_a = (state_r == S_DIVD) ? dmag_r : nmag_r;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a),
    .divisor  (g_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res_s = neg_r ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});

  assign in_req.ready    = (state_r == S_IDLE);
  assign out_res.valid   = out_valid_r;
  assign out_res.res_num = res_num_r;
  assign out_res.res_den = res_den_r;
  assign out_res.status  = status_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      step_r      <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_res.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            op_r   <= in_req.req_type;
            an_r   <= in_req.a_num;
            ad_r   <= in_req.a_den;
            bn_r   <= in_req.b_num;
            bd_r   <= in_req.b_den;
            step_r <= '0;
            neg_r  <= 1'b0;
            qn_r   <= '0;
            qd_r   <= '0;
            if (in_req.a_den == '0 || in_req.b_den == '0) begin
              st_r    <= ST_ZERO_DEN;
              state_r <= S_DONE;
            end else if (in_req.req_type == OP_DIV && in_req.b_num == '0) begin
              st_r    <= ST_DIV_ZERO;
              state_r <= S_DONE;
            end else begin
              st_r    <= ST_OK;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          step_r <= step_r + 1'b1;
          unique case (step_r)
            2'd0: ;
            2'd1: num_r <= prod_x;
            2'd2: begin
              if (op_r == OP_ADD)      num_r <= num_r + prod_x;
              else if (op_r == OP_SUB) num_r <= num_r - prod_x;
            end
            default: begin
              neg_r   <= num_fin[MAG_W-1] ^ den_x[MAG_W-1];
              x_r     <= num_fin[MAG_W-1] ? MAG_W'(-num_fin) : MAG_W'(num_fin);
              nmag_r  <= num_fin[MAG_W-1] ? MAG_W'(-num_fin) : MAG_W'(num_fin);
              y_r     <= den_x[MAG_W-1] ? MAG_W'(-den_x) : MAG_W'(den_x);
              dmag_r  <= den_x[MAG_W-1] ? MAG_W'(-den_x) : MAG_W'(den_x);
              k_r     <= '0;
              state_r <= S_GCD;
            end
          endcase
        end
        S_GCD: begin
          // binary gcd, one step per cycle
          priority if (x_r == '0) begin
            g_r         <= y_r << k_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIVN;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r >= y_r) begin
            x_r <= (x_r - y_r) >> 1;
          end else begin
            y_r <= (y_r - x_r) >> 1;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            qn_r        <= div_q;
            div_start_r <= 1'b1;
            state_r     <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            qd_r    <= div_q;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            res_num_r   <= RES_NUM_W'(res_s);
            res_den_r   <= RES_DEN_W'(qd_r);
            status_r    <= st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: dv/rational_arith_unit_top_test.sv
`timescale 1ns / 100ps
`default_nettype none

module rational_arith_unit_top_test;
  import rau_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RANDOM_ITEMS   = 1050;

  // Expected quotient of one request
  typedef struct {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    status_t                     status;
  } rat_result_t;

  logic clk;
  logic rst_n;
  int   error_count;
  int   idle_cycles;
  int   in_idle_pct;
  int   out_stall_pct;

  rau_in_if  in_req ();
  rau_out_if out_res ();

  rational_arith_unit_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_res(out_res.source)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint gcd_of(input longint x, input longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Exact rational arithmetic, reduced by gcd
  function automatic rat_result_t reduce_rational(input op_t op,
      input logic signed [15:0] an, input logic signed [15:0] ad,
      input logic signed [15:0] bn, input logic signed [15:0] bd);
    rat_result_t r;
    longint      n;
    longint      d;
    longint      g;
    r.res_num = '0;
    r.res_den = '0;
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (op == OP_DIV && bn == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (op)
      OP_ADD: begin
        n = longint'(an) * bd + longint'(bn) * ad;
        d = longint'(ad) * bd;
      end
      OP_SUB: begin
        n = longint'(an) * bd - longint'(bn) * ad;
        d = longint'(ad) * bd;
      end
      OP_MUL: begin
        n = longint'(an) * bn;
        d = longint'(ad) * bd;
      end
      default: begin
        n = longint'(an) * bd;
        d = longint'(ad) * bn;
      end
    endcase
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    g = gcd_of(n < 0 ? -n : n, d);
    r.res_num = RES_NUM_W'(n / g);
    r.res_den = RES_DEN_W'(d / g);
    r.status  = ST_OK;
    return r;
  endfunction

  class quotient_board;
    rat_result_t pending_q[$];

    function void note_request(op_t op, logic signed [15:0] an,
        logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
      pending_q.push_back(reduce_rational(op, an, ad, bn, bd));
    endfunction

    task check_result(logic signed [RES_NUM_W-1:0] num,
        logic [RES_DEN_W-1:0] den, logic [1:0] st);
      rat_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = pending_q.pop_front();
      if (num !== e.res_num)
        report_mismatch($sformatf("res_num %0d, expected %0d", num, e.res_num));
      if (den !== e.res_den)
        report_mismatch($sformatf("res_den %0d, expected %0d", den, e.res_den));
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
    endtask
  endclass

  quotient_board board;

  // Monitor: record accepted requests, check results, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_req.valid && in_req.ready)
        board.note_request(op_t'(in_req.req_type), in_req.a_num, in_req.a_den,
                           in_req.b_num, in_req.b_den);
      if (out_res.valid && out_res.ready)
        board.check_result(out_res.res_num, out_res.res_den, out_res.status);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(6)) - 3);
      4, 5: return 16'($urandom);
      default: return 16'(int'($urandom_range(400)) - 200);
    endcase
  endfunction

  function automatic logic [15:0] pick_den();
    // mostly nonzero, a few zeros to hit the error path
    if ($urandom_range(39) == 0) return 16'h0000;
    return pick_value() == 16'h0000 ? 16'h0001 : pick_value();
  endfunction

  // Send one request, with random idle before it
  task automatic send_request(input op_t op, input logic [15:0] an,
      input logic [15:0] ad, input logic [15:0] bn, input logic [15:0] bd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.req_type <= op;
    in_req.a_num    <= an;
    in_req.a_den    <= ad;
    in_req.b_num    <= bn;
    in_req.b_den    <= bd;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  initial begin
    op_t ops[4];
    int  phase;
    board = new();
    ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    error_count   = 0;
    idle_cycles   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    in_req.valid    = 1'b0;
    in_req.req_type = '0;
    in_req.a_num    = '0;
    in_req.a_den    = '0;
    in_req.b_num    = '0;
    in_req.b_den    = '0;
    out_res.ready   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, errors, zero result
    foreach (ops[i]) begin
      send_request(ops[i], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(ops[i], 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_request(ops[i], 16'h8000, 16'h0001, 16'h7fff, 16'hffff);
      send_request(ops[i], 16'h0003, 16'h0000, 16'h0001, 16'h0002);
    end
    send_request(OP_ADD, 16'h0001, 16'h0002, 16'h0001, 16'h0000);
    send_request(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0005);
    send_request(OP_DIV, 16'h0005, 16'h0007, 16'h0000, 16'h0003);
    send_request(OP_SUB, 16'h0002, 16'h0004, 16'h0001, 16'h0002);
    send_request(OP_MUL, 16'h0000, 16'hfffd, 16'h0009, 16'h0004);
    send_request(OP_ADD, 16'h0006, 16'hfff7, 16'hfffc, 16'h0006);
    send_request(OP_DIV, 16'h7fff, 16'h7ffe, 16'h7ffe, 16'h7fff);

    // Random, through the idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n * 5) / RANDOM_ITEMS;
      case (phase)
        1: begin in_idle_pct = 47; out_stall_pct = 0; end
        2: begin in_idle_pct = 0;  out_stall_pct = 47; end
        3: begin in_idle_pct = 16; out_stall_pct = 16; end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase
      send_request(op_t'($urandom_range(3)), pick_value(), pick_den(),
                   pick_value(), pick_den());
    end
    in_req.valid <= 1'b0;
    out_stall_pct = 0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // every accepted request must have produced its result by now
    if (board.pending_q.size() != 0)
      report_mismatch("results missing at end of run");
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
